// File: hdl/mecanum_wheel_mixer_limited_top_assert.svh
// assertion macros for the wheel mixer
`ifndef MECANUM_WHEEL_MIXER_LIMITED_TOP_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_LIMITED_TOP_ASSERT_SVH
`ifndef SYNTH
`define MWML_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define MWML_ASSERT_HOLD(name, cond, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);
`else
`define MWML_ASSERT(name, prop, msg)
`define MWML_ASSERT_HOLD(name, cond, sig, msg)
`endif
`endif

// File: hdl/mwml_pkg.sv
package mwml_pkg;

	localparam int SPEED_WIDTH = 16;
	localparam int LIMIT_W = 15;
	localparam int WHEEL_W = SPEED_WIDTH + 2;
	localparam int MAG_W = SPEED_WIDTH + 1;
	localparam int PROD_W = MAG_W + LIMIT_W;
	localparam int QUO_W = LIMIT_W;
	localparam int DIV_BITS = 3;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;
	localparam int RES_W = (WHEEL_W > QUO_W + 1) ? WHEEL_W : QUO_W + 1;
	localparam int NUM_WHEELS = 4;
	localparam int NUM_STAGES = DIV_STAGES + 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef logic signed [SPEED_WIDTH-1:0] speed_t;
	typedef logic signed [WHEEL_W-1:0] wheel_t;
	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [QUO_W-1:0] quo_t;
	typedef logic signed [RES_W-1:0] res_t;
	typedef logic [PADDR_W-1:0] paddr_t;
	typedef logic [PDATA_W-1:0] pdata_t;

	typedef wheel_t [NUM_WHEELS-1:0] wheel_vec_t;
	typedef mag_t [NUM_WHEELS-1:0] mag_vec_t;
	typedef prod_t [NUM_WHEELS-1:0] prod_vec_t;
	typedef quo_t [NUM_WHEELS-1:0] quo_vec_t;
	typedef speed_t [NUM_WHEELS-1:0] speed_vec_t;

	// register index, taken from paddr above the byte offset
	localparam logic [PADDR_W-3:0] REG_SPEED_LIMIT = '0;

	localparam limit_t LIMIT_RESET = LIMIT_W'(8500);
	localparam res_t OUT_TOP = RES_W'((64'sd1 <<< (SPEED_WIDTH - 1)) - 64'sd1);

	typedef struct packed {
		mag_t peak;
		logic scaled;
		logic [NUM_WHEELS-1:0] neg;
		wheel_vec_t wheel;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		mag_vec_t rem;
		quo_vec_t lo;
		quo_vec_t quo;
	} div_stage_t;

	typedef struct packed {
		logic q;
		mag_t r;
	} div_step_t;

	function automatic mag_t magnitude(wheel_t w);
		wheel_t n;
		n = -w;
		return w[WHEEL_W-1] ? n[MAG_W-1:0] : w[MAG_W-1:0];
	endfunction

	// one restoring step: bring down a dividend bit, subtract if it fits
	function automatic div_step_t div_step(mag_t rem, logic lo_bit, mag_t peak);
		logic [MAG_W:0] t;
		logic [MAG_W:0] d;
		div_step_t o;
		t = {rem, lo_bit};
		d = t - {1'b0, peak};
		if (t >= {1'b0, peak}) begin
			o.q = 1'b1;
			o.r = d[MAG_W-1:0];
		end else begin
			o.q = 1'b0;
			o.r = t[MAG_W-1:0];
		end
		return o;
	endfunction

	function automatic speed_t clamp_out(res_t v);
		res_t lo;
		lo = -OUT_TOP;
		if (v > OUT_TOP) begin
			return OUT_TOP[SPEED_WIDTH-1:0];
		end else if (v < lo) begin
			return lo[SPEED_WIDTH-1:0];
		end
		return v[SPEED_WIDTH-1:0];
	endfunction

endpackage

// File: hdl/mecanum_wheel_mixer_limited_top.sv
// channel | handshake            | fields
// cfg     | apb write/read       | speed_limit at byte address 0
// in      | in_valid / in_stall  | vel_forward, vel_side, vel_turn
// out     | out_valid / out_stall| wheel_zero..wheel_three, was_scaled
//
// one word per cycle sustained while out_stall stays low
// depth is set by the limiting divider: three quotient bits per stage, five stages
// a stage holds only while it is full and the one after it holds, so in_stall
// follows out_stall back through full stages
// reset clears all stage valid bits and loads speed_limit with 8500
`include "mecanum_wheel_mixer_limited_top_assert.svh"

module mecanum_wheel_mixer_limited_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  mwml_pkg::paddr_t    paddr,
	input  mwml_pkg::pdata_t    pwdata,
	output mwml_pkg::pdata_t    prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  mwml_pkg::speed_t    vel_forward,
	input  mwml_pkg::speed_t    vel_side,
	input  mwml_pkg::speed_t    vel_turn,
	output logic                out_valid,
	input  logic                out_stall,
	output mwml_pkg::speed_t    wheel_zero,
	output mwml_pkg::speed_t    wheel_one,
	output mwml_pkg::speed_t    wheel_two,
	output mwml_pkg::speed_t    wheel_three,
	output logic                was_scaled
);
	import mwml_pkg::*;

	localparam int DIV_FIRST = 4;
	localparam int DIV_LAST = DIV_FIRST + DIV_STAGES - 1;
	localparam int OUT_IDX = NUM_STAGES - 1;

	limit_t speed_limit_q;
	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] stage_en;
	logic [NUM_STAGES-1:0] vld_in;

	wheel_vec_t wheel_s1;
	wheel_vec_t wheel_s2;
	mag_vec_t mag_s2;
	logic [NUM_WHEELS-1:0] neg_s2;
	mag_t [1:0] pair_s2;
	ctrl_t ctrl_s3;
	mag_vec_t mag_s3;
	ctrl_t ctrl_s4;
	prod_vec_t prod_s4;
	div_stage_t div_s [DIV_STAGES];   // stages 5 to 9
	speed_vec_t wheel_s10;
	logic scaled_s10;

	wheel_t fwd_x, side_x, turn_x;
	mag_vec_t mag_c;
	mag_t peak_c;
	div_stage_t div_src [DIV_STAGES];
	div_stage_t div_nxt [DIV_STAGES];
	div_stage_t div_cur;
	div_step_t step_c;
	div_stage_t fin;
	res_t quo_ext;
	res_t res_c;
	speed_vec_t out_nxt;

	logic s3_scaled;
	logic div_scaled;
	logic div_held;
	logic fin_scaled;
	logic rem_ok;
	logic quo_ok;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_SPEED_LIMIT) ? PDATA_W'(speed_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_SPEED_LIMIT) begin
			speed_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// flow control
	always_comb begin
		stage_en[OUT_IDX] = !stage_vld_q[OUT_IDX] || !out_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	assign vld_in = {stage_vld_q[NUM_STAGES-2:0], in_valid};
	assign in_stall = !stage_en[0];
	assign out_valid = stage_vld_q[OUT_IDX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// stage 1: wheel sums
	assign fwd_x = wheel_t'(vel_forward);
	assign side_x = wheel_t'(vel_side);
	assign turn_x = wheel_t'(vel_turn);

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			wheel_s1[0] <= fwd_x - side_x + turn_x;
			wheel_s1[1] <= -fwd_x - side_x + turn_x;
			wheel_s1[2] <= -fwd_x + side_x + turn_x;
			wheel_s1[3] <= fwd_x + side_x + turn_x;
		end
	end

	// stage 2: magnitudes and pairwise max
	always_comb begin
		for (int w = 0; w < NUM_WHEELS; w++) begin
			mag_c[w] = magnitude(wheel_s1[w]);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			wheel_s2 <= wheel_s1;
			mag_s2 <= mag_c;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				neg_s2[w] <= wheel_s1[w][WHEEL_W-1];
			end
			pair_s2[0] <= (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
			pair_s2[1] <= (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
		end
	end

	// stage 3: peak and limit test
	assign peak_c = (pair_s2[0] > pair_s2[1]) ? pair_s2[0] : pair_s2[1];

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			ctrl_s3.peak <= peak_c;
			ctrl_s3.scaled <= peak_c > MAG_W'(speed_limit_q);
			ctrl_s3.neg <= neg_s2;
			ctrl_s3.wheel <= wheel_s2;
			mag_s3 <= mag_s2;
		end
	end

	// stage 4: magnitude times limit
	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			ctrl_s4 <= ctrl_s3;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				prod_s4[w] <= PROD_W'(mag_s3[w]) * PROD_W'(speed_limit_q);
			end
		end
	end

	// stages 5 to 9: divide by peak, quotient fits in QUO_W bits since |w| <= peak
	always_comb begin
		div_src[0].ctrl = ctrl_s4;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			div_src[0].rem[w] = prod_s4[w][PROD_W-1:QUO_W];
			div_src[0].lo[w] = prod_s4[w][QUO_W-1:0];
			div_src[0].quo[w] = '0;
		end
		for (int j = 1; j < DIV_STAGES; j++) begin
			div_src[j] = div_s[j-1];
		end
	end

	always_comb begin
		div_cur = div_src[0];
		step_c = '0;
		for (int j = 0; j < DIV_STAGES; j++) begin
			div_cur = div_src[j];
			for (int b = 0; b < DIV_BITS; b++) begin
				for (int w = 0; w < NUM_WHEELS; w++) begin
					step_c = div_step(div_cur.rem[w], div_cur.lo[w][QUO_W-1],
						div_cur.ctrl.peak);
					div_cur.rem[w] = step_c.r;
					div_cur.lo[w] = {div_cur.lo[w][QUO_W-2:0], 1'b0};
					div_cur.quo[w] = {div_cur.quo[w][QUO_W-2:0], step_c.q};
				end
			end
			div_nxt[j] = div_cur;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (stage_en[DIV_FIRST+j]) begin
				div_s[j] <= div_nxt[j];
			end
		end
	end

	// stage 10: sign, select and clamp
	assign fin = div_s[DIV_STAGES-1];

	always_comb begin
		quo_ext = '0;
		res_c = '0;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			quo_ext = res_t'($signed({1'b0, fin.quo[w]}));
			if (fin.ctrl.scaled) begin
				res_c = fin.ctrl.neg[w] ? -quo_ext : quo_ext;
			end else begin
				res_c = res_t'($signed(fin.ctrl.wheel[w]));
			end
			out_nxt[w] = clamp_out(res_c);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[OUT_IDX]) begin
			wheel_s10 <= out_nxt;
			scaled_s10 <= fin.ctrl.scaled;
		end
	end

	assign wheel_zero = wheel_s10[0];
	assign wheel_one = wheel_s10[1];
	assign wheel_two = wheel_s10[2];
	assign wheel_three = wheel_s10[3];
	assign was_scaled = scaled_s10;

	// terms for the checks below
	assign s3_scaled = stage_vld_q[2] && ctrl_s3.scaled;
	assign div_scaled = stage_vld_q[DIV_FIRST] && div_s[0].ctrl.scaled;
	assign div_held = stage_vld_q[DIV_FIRST] && !stage_en[DIV_FIRST];
	assign fin_scaled = stage_vld_q[DIV_LAST] && fin.ctrl.scaled;

	always_comb begin
		rem_ok = 1'b1;
		quo_ok = 1'b1;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			rem_ok = rem_ok && (div_s[0].rem[w] < div_s[0].ctrl.peak);
			quo_ok = quo_ok && (fin.quo[w] <= speed_limit_q);
		end
	end

	`MWML_ASSERT(a_peak_nonzero, s3_scaled |-> ctrl_s3.peak != '0, "scaled word with zero peak")
	`MWML_ASSERT(a_rem_below_peak, div_scaled |-> rem_ok, "divider remainder not below peak")
	`MWML_ASSERT(a_quo_within_limit, fin_scaled |-> quo_ok, "scaled wheel above limit")
	`MWML_ASSERT_HOLD(a_div_holds, div_held, div_s[0], "held divider stage changed")

endmodule

// File: verif/mecanum_wheel_mixer_limited_top_test.sv
module mecanum_wheel_mixer_limited_top_test;

	import mwml_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 11;
	localparam int REPORT_MAX = 10;
	localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'b1;
	localparam int VEL_HI = 32767;
	localparam int VEL_LO = -32768;

	typedef struct {
		speed_vec_t wheel;
		logic scaled;
	} wheel_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	paddr_t paddr = '0;
	pdata_t pwdata = '0;
	pdata_t prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	speed_t vel_forward = '0;
	speed_t vel_side = '0;
	speed_t vel_turn = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	speed_t wheel_zero;
	speed_t wheel_one;
	speed_t wheel_two;
	speed_t wheel_three;
	logic was_scaled;

	wheel_set_t pending_wheels[$];
	limit_t limit_shadow = LIMIT_RESET;
	bit source_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	int hold_off_cycles = 0;
	int unsigned cycle_count = 0;
	int mismatch_count = 0;
	int commands_sent = 0;
	int words_checked = 0;
	int scaled_seen = 0;
	int limit_settings = 0;

	mecanum_wheel_mixer_limited_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vel_forward(vel_forward),
		.vel_side(vel_side),
		.vel_turn(vel_turn),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wheel_zero(wheel_zero),
		.wheel_one(wheel_one),
		.wheel_two(wheel_two),
		.wheel_three(wheel_three),
		.was_scaled(was_scaled)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
			pending_wheels.size());
		$display("mecanum_wheel_mixer_limited_top_test: FAIL");
		$finish;
	end

	// four signed wheel sums, then proportional scaling when the peak is over the limit, then a clamp to +/-VEL_HI
	function automatic wheel_set_t mix_wheels(speed_t fwd, speed_t side, speed_t turn,
			limit_t lim);
		longint sums[4];
		longint peak;
		longint mag;
		longint v;
		wheel_set_t r;
		sums[0] = longint'(fwd) - longint'(side) + longint'(turn);
		sums[1] = -longint'(fwd) - longint'(side) + longint'(turn);
		sums[2] = -longint'(fwd) + longint'(side) + longint'(turn);
		sums[3] = longint'(fwd) + longint'(side) + longint'(turn);
		peak = 0;
		for (int i = 0; i < 4; i++) begin
			mag = (sums[i] < 0) ? -sums[i] : sums[i];
			if (mag > peak)
				peak = mag;
		end
		r.scaled = (peak > longint'(lim));
		for (int i = 0; i < 4; i++) begin
			v = sums[i];
			if (r.scaled)
				v = (v * longint'(lim)) / peak;
			if (v > VEL_HI)
				v = VEL_HI;
			if (v < -VEL_HI)
				v = -VEL_HI;
			r.wheel[i] = speed_t'(v);
		end
		return r;
	endfunction

	function automatic void flag_mismatch(string msg);
		if (mismatch_count < REPORT_MAX)
			$display("[%0d] mismatch: %s", cycle_count, msg);
		mismatch_count++;
	endfunction

	// result side: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		wheel_set_t exp_w;
		speed_vec_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got[0] = wheel_zero;
			got[1] = wheel_one;
			got[2] = wheel_two;
			got[3] = wheel_three;
			if (pending_wheels.size() == 0) begin
				flag_mismatch("result word with nothing expected");
			end else begin
				exp_w = pending_wheels.pop_front();
				words_checked++;
				if (exp_w.scaled)
					scaled_seen++;
				for (int i = 0; i < 4; i++) begin
					if (got[i] !== exp_w.wheel[i])
						flag_mismatch($sformatf("wheel %0d expected %0d got %0d",
							i, exp_w.wheel[i], got[i]));
				end
				if (was_scaled !== exp_w.scaled)
					flag_mismatch($sformatf("was_scaled expected %0b got %0b",
						exp_w.scaled, was_scaled));
			end
		end
	end

	// receiver pacing, with an optional long hold-off
	initial begin : sink_pacing
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= sink_gaps && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_command(input speed_t fwd, input speed_t side, input speed_t turn);
		while (source_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vel_forward <= fwd;
		vel_side <= side;
		vel_turn <= turn;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pending_wheels.push_back(mix_wheels(fwd, side, turn, limit_shadow));
		commands_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_wheels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [PADDR_W-3:0] idx, input pdata_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SPEED_LIMIT) begin
			limit_shadow = value[LIMIT_W-1:0];
			limit_settings++;
		end
		@(posedge clk);
	endtask

	task automatic check_limit_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_SPEED_LIMIT, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (prdata !== pdata_t'(limit_shadow))
			flag_mismatch($sformatf("speed_limit read expected %0d got %0d",
				limit_shadow, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic speed_t pick_speed();
		int v;
		case ($urandom_range(4))
			0, 1: v = $urandom_range(65535) - 32768;
			2: begin
				// near the active limit so scaling flips on and off
				v = $urandom_range(limit_shadow / 2 + 1);
				if ($urandom_range(1))
					v = -v;
			end
			3: begin
				case ($urandom_range(4))
					0: v = VEL_HI;
					1: v = VEL_LO;
					2: v = -1;
					3: v = 1;
					default: v = 0;
				endcase
			end
			default: v = $urandom_range(511) - 256;
		endcase
		return speed_t'(v);
	endfunction

	task automatic test_reset_defaults();
		check_limit_readback();
		send_command(0, 0, 0);
		// peak exactly at the limit stays unscaled
		send_command(speed_t'(8500), 0, 0);
		send_command(0, 0, speed_t'(-8500));
		send_command(speed_t'(8501), 0, 0);
		send_command(speed_t'(VEL_HI), speed_t'(VEL_HI), speed_t'(VEL_HI));
		send_command(speed_t'(VEL_LO), speed_t'(VEL_LO), speed_t'(VEL_LO));
		send_command(speed_t'(VEL_LO), speed_t'(VEL_HI), speed_t'(VEL_LO));
		send_command(speed_t'(VEL_HI), speed_t'(VEL_LO), speed_t'(VEL_HI));
		send_command(1, -1, 1);
		send_command(-1, -1, -1);
		drain_results();
	endtask

	task automatic test_limit_extremes();
		// bit 15 set but masked off: limit becomes zero
		write_reg(REG_SPEED_LIMIT, 32'h0001_8000);
		check_limit_readback();
		send_command(0, 0, 0);
		send_command(1, 0, 0);
		send_command(speed_t'(VEL_LO), 0, 0);
		drain_results();
		// writes to an unmapped index leave the limit alone
		write_reg(REG_UNMAPPED, 32'd123);
		check_limit_readback();
		write_reg(REG_SPEED_LIMIT, 32'd1);
		send_command(1, 0, 0);
		send_command(2, 1, 0);
		drain_results();
		write_reg(REG_SPEED_LIMIT, 32'h0000_7FFF);
		check_limit_readback();
		send_command(speed_t'(VEL_HI), 0, 0);
		send_command(speed_t'(VEL_LO), 0, 0);
		send_command(speed_t'(VEL_HI), speed_t'(VEL_HI), speed_t'(VEL_HI));
		drain_results();
	endtask

	task automatic test_random_traffic(input int count, input pdata_t lim, input bit gaps);
		write_reg(REG_SPEED_LIMIT, lim);
		check_limit_readback();
		source_gaps = gaps;
		sink_gaps = gaps;
		repeat (count) send_command(pick_speed(), pick_speed(), pick_speed());
		drain_results();
		source_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		write_reg(REG_SPEED_LIMIT, pdata_t'($urandom_range(1, 4000)));
		source_gaps = 1'b0;
		hold_off_cycles = 150;
		// pipeline fills and in_stall has to rise while the sink is held
		repeat (40) send_command(pick_speed(), pick_speed(), pick_speed());
		source_gaps = 1'b1;
		drain_results();
	endtask

	task automatic test_paused_source();
		repeat (20) send_command(pick_speed(), pick_speed(), pick_speed());
		drain_results();
		repeat (20) send_command(pick_speed(), pick_speed(), pick_speed());
		drain_results();
	endtask

	initial begin : main_flow
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_limit_extremes();
		test_random_traffic(150, pdata_t'(LIMIT_RESET), 1'b1);
		test_random_traffic(150, 32'h0000_7FFF, 1'b1);
		test_random_traffic(150, 32'd1, 1'b0);
		test_random_traffic(150, pdata_t'($urandom_range(1, 32767)), 1'b1);
		test_random_traffic(150, pdata_t'($urandom_range(2, 300)), 1'b1);
		test_backpressure();
		test_paused_source();
		$display("sent %0d commands over %0d limit settings; %0d wheel words checked",
			commands_sent, limit_settings, words_checked);
		$display("%0d of them scaled down, %0d mismatches", scaled_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("mecanum_wheel_mixer_limited_top_test: PASS");
		end else begin
			$display("mecanum_wheel_mixer_limited_top_test: FAIL");
		end
		$finish;
	end

endmodule
